// File: rtl/fchk_pkg.sv
// Shared types and constants for the CRC-16 frame checker.
package fchk_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_MSB     = 16'h8000;

    localparam logic [15:0] HDR_LEN     = 16'd11;
    localparam logic [15:0] MIN_FRAME   = 16'd13;
    localparam logic [15:0] MAX_PAYLOAD = 16'd256;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam int          HDR_WORDS   = 5;

    localparam int          CFG_INDEX_W = 1;
    localparam int          CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PREAMBLE = 1'b0,
        REG_SYNC     = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_PREAMBLE = 3'd2,
        ST_SYNC     = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_TOO_LONG = 3'd5,
        ST_CRC      = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        status_t     status;
        logic [15:0] source_address;
        logic [15:0] dest_address;
        logic [7:0]  message_type;
        logic [15:0] payload_count;
        logic [15:0] received_check;
    } out_beat_t;

endpackage

// File: rtl/fchk_crc8.sv
// One-byte CRC-16/CCITT update, MSB first, unrolled over eight bits.
module fchk_crc8
    import fchk_pkg::*;
(
    input  logic [15:0] crc,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

// File: rtl/fchk_core.sv
// Frame state, header capture, payload forwarding and end-of-frame status.
module fchk_core
    import fchk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_beat_t    beat,
    input  logic [15:0] expected_preamble,
    input  logic [15:0] expected_sync,
    output logic        has_result,
    output out_beat_t   result
);

    logic [15:0] byte_count_reg;
    logic        count_ovf_reg;
    logic [7:0]  delay0_reg;
    logic [7:0]  delay1_reg;
    logic [15:0] crc_reg;
    logic [15:0] hdr_reg [HDR_WORDS];
    logic [7:0]  type_reg;

    logic [15:0] hdr_next [HDR_WORDS];
    logic [7:0]  type_next;
    logic [15:0] crc_upd;
    logic [15:0] crc_next;
    logic        pay_ok;
    logic        frame_ovf;
    logic [15:0] frame_len;
    logic [15:0] plen;
    logic [15:0] rx_check;
    status_t     status;

    fchk_crc8 u_crc (
        .crc     (crc_reg),
        .data    (delay1_reg),
        .crc_out (crc_upd)
    );

    assign pay_ok    = count_ovf_reg || (byte_count_reg >= MIN_FRAME);
    assign crc_next  = (count_ovf_reg || (byte_count_reg >= 16'd2)) ? crc_upd : crc_reg;
    assign frame_ovf = count_ovf_reg || (byte_count_reg == COUNT_MAX);
    assign frame_len = frame_ovf ? COUNT_MAX : byte_count_reg + 16'd1;
    assign plen      = frame_len - MIN_FRAME;
    assign rx_check  = {delay0_reg, beat.data_byte};

    // header bytes shift into their 16-bit word, big-endian
    always_comb
    begin
        for (int k = 0; k < HDR_WORDS; k++)
        begin
            hdr_next[k] = hdr_reg[k];
            if (!count_ovf_reg && (byte_count_reg < HDR_LEN - 16'd1)
                && (byte_count_reg[3:1] == 3'(k)))
                hdr_next[k] = {hdr_reg[k][7:0], beat.data_byte};
        end
        type_next = type_reg;
        if (!count_ovf_reg && (byte_count_reg == HDR_LEN - 16'd1))
            type_next = beat.data_byte;
    end

    always_comb
    begin
        if (hdr_next[0] != expected_preamble)
            status = ST_PREAMBLE;
        else if (hdr_next[1] != expected_sync)
            status = ST_SYNC;
        else if (frame_ovf)
            status = ST_TOO_LONG;
        else if (hdr_next[2] != frame_len)
            status = ST_LENGTH;
        else if (plen > MAX_PAYLOAD)
            status = ST_TOO_LONG;
        else if (rx_check != crc_next)
            status = ST_CRC;
        else
            status = ST_OK;
    end

    always_comb
    begin
        result               = '0;
        result.payload_valid = pay_ok;
        result.payload_byte  = pay_ok ? delay1_reg : 8'h00;
        if (beat.last_byte)
        begin
            result.frame_done = 1'b1;
            if (!frame_ovf && (frame_len < MIN_FRAME))
                result.status = ST_SHORT;
            else
            begin
                result.status         = status;
                result.source_address = hdr_next[3];
                result.dest_address   = hdr_next[4];
                result.message_type   = type_next;
                result.payload_count  = plen;
                result.received_check = rx_check;
            end
        end
    end

    assign has_result = beat.last_byte || pay_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            count_ovf_reg  <= 1'b0;
            delay0_reg     <= '0;
            delay1_reg     <= '0;
            crc_reg        <= CRC_INIT;
            type_reg       <= '0;
            for (int k = 0; k < HDR_WORDS; k++)
                hdr_reg[k] <= '0;
        end
        else if (step)
        begin
            if (beat.last_byte)
            begin
                byte_count_reg <= '0;
                count_ovf_reg  <= 1'b0;
                delay0_reg     <= '0;
                delay1_reg     <= '0;
                crc_reg        <= CRC_INIT;
                type_reg       <= '0;
                for (int k = 0; k < HDR_WORDS; k++)
                    hdr_reg[k] <= '0;
            end
            else
            begin
                if (byte_count_reg == COUNT_MAX)
                    count_ovf_reg <= 1'b1;
                else if (!count_ovf_reg)
                    byte_count_reg <= byte_count_reg + 16'd1;
                delay1_reg <= delay0_reg;
                delay0_reg <= beat.data_byte;
                crc_reg    <= crc_next;
                type_reg   <= type_next;
                for (int k = 0; k < HDR_WORDS; k++)
                    hdr_reg[k] <= hdr_next[k];
            end
        end
    end

    // once saturated, the count stays pinned until the frame ends
    assert property (@(posedge clk) disable iff (!rst_n)
        count_ovf_reg |-> byte_count_reg == COUNT_MAX)
        else $error("overflow flag set with unsaturated count");

    // the last byte of a frame always returns the frame state to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && beat.last_byte |=> byte_count_reg == 16'd0 && !count_ovf_reg
                                  && crc_reg == CRC_INIT)
        else $error("frame state not cleared after last byte");

    // a short frame cannot also forward payload
    assert property (@(posedge clk) disable iff (!rst_n)
        beat.last_byte && result.status == ST_SHORT |-> !result.payload_valid)
        else $error("short frame forwarded payload");

endmodule

// File: rtl/frame_checker_crc16.sv
// Top level of the streaming CRC-16 frame checker.
//
// Usage:
//   Frame bytes enter on the byte channel (byte_valid / byte_stall /
//   byte_data), one beat per byte, with last_byte set on the final byte.
//   Results leave on the result channel (result_valid / result_stall /
//   result_data). A beat yields a result when it releases a payload byte
//   (the byte two positions back, once the header is past) or when it
//   closes the frame; the closing result carries the status and the
//   header summary.
//   Path: a byte accepted into the input register is processed from
//   there into the result register once that register can advance; the
//   receiver takes it from the result register.
//   Throughput: one byte per cycle unless the result channel stalls; the
//   CRC update for a byte is a single unrolled eight-bit XOR network from
//   the core's second delay register and CRC register to the CRC register.
//   Stall: a held result blocks the input register; byte_stall rises
//   only when the input register is full and the result register cannot
//   drain. Nothing is dropped or repeated.
//   Reset: all frame state returns to idle, the CRC to 0xFFFF, and the
//   expected preamble and sync registers to zero.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 preamble, 1 sync); write only while no frame is in flight.
module frame_checker_crc16
    import fchk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  in_beat_t               byte_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_beat_t              result_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic        in_valid_reg;
    in_beat_t    in_beat_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_beat_t   out_beat_reg;
    logic [15:0] preamble_reg;
    logic [15:0] sync_reg;

    logic        advance;   // result register can take a new beat
    logic        step;      // input register beat is processed this cycle
    logic        has_result;
    out_beat_t   core_result;

    assign advance    = !out_valid_reg || !result_stall;
    assign step       = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg <= '0;
            sync_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PREAMBLE: preamble_reg <= cfg_wdata;
                REG_SYNC:     sync_reg     <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!byte_stall)
            in_valid_reg <= byte_valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
            in_beat_reg <= byte_data;
    end

    fchk_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .beat              (in_beat_reg),
        .expected_preamble (preamble_reg),
        .expected_sync     (sync_reg),
        .has_result        (has_result),
        .result            (core_result)
    );

    // result register
    assign out_valid_next = advance ? (in_valid_reg && has_result) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && has_result)
            out_beat_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_beat_reg;

    // a beat held back by a stalled output must still be there next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && result_stall |=> in_valid_reg)
        else $error("input beat lost under output stall");

    // non-final results carry only a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.frame_done |->
            out_beat_reg.payload_valid && out_beat_reg.status == ST_OK
            && out_beat_reg.payload_count == 16'd0
            && out_beat_reg.received_check == 16'd0)
        else $error("non-final result with summary fields set");

    // an empty payload slot reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.payload_valid |->
            out_beat_reg.payload_byte == 8'h00)
        else $error("payload byte set without payload_valid");

endmodule
